[hw/rtl/ssd_pkg.sv]
`default_nettype none
package ssd_pkg;
    localparam int LIST_DEPTH = 32;
    localparam int INDEX_BITS = 16;
    localparam int ELEM_W     = 16;
    localparam int N_CELLS    = 2 * LIST_DEPTH;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] OP_LEFT  = 2'd0;
    localparam logic [1:0] OP_RIGHT = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    // one distinct value with its left multiplicity and right presence
    typedef struct packed {
        logic                  vld;
        logic [INDEX_BITS-1:0] value;
        logic [CNT_W-1:0]      lcnt;
        logic                  rflg;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic dec;
    } t_cell_ctl;
endpackage
`default_nettype wire

[hw/rtl/ssd_if.sv]
`default_nettype none
interface ssd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] index_value;
    modport source (output valid, op, index_value, input ready);
    modport sink   (input valid, op, index_value, output ready);
endinterface

interface ssd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] element;
    logic        valid_res;
    logic        last;
    logic        overflow;
    modport source (output valid, element, valid_res, last, overflow, input ready);
    modport sink   (input valid, element, valid_res, last, overflow, output ready);
endinterface
`default_nettype wire

[hw/rtl/ssd_cell.sv]
`default_nettype none
module ssd_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire ssd_pkg::t_cell_ctl i_ctl,
    input  wire ssd_pkg::t_entry    i_tok,
    input  wire ssd_pkg::t_entry    i_right,
    output ssd_pkg::t_entry     o_tok,
    output ssd_pkg::t_entry     o_entry
);
    import ssd_pkg::*;

    t_entry r_ent, n_ent;
    t_entry r_tok, n_tok;

    always_comb begin
        n_ent = r_ent;
        n_tok = '0;
        if (i_ctl.shift) begin
            n_ent = i_right;
        end else if (i_ctl.dec) begin
            n_ent.lcnt = r_ent.lcnt - CNT_W'(1);
        end else if (i_tok.vld) begin
            if (!r_ent.vld) begin
                n_ent = i_tok;
            end else if (r_ent.value == i_tok.value) begin
                // merge duplicates into one entry
                n_ent.lcnt = r_ent.lcnt + i_tok.lcnt;
                n_ent.rflg = r_ent.rflg | i_tok.rflg;
            end else if (i_tok.value < r_ent.value) begin
                n_ent = i_tok;
                n_tok = r_ent;
            end else begin
                n_tok = i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
            r_tok <= '0;
        end else begin
            r_ent <= n_ent;
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_entry = r_ent;
endmodule
`default_nettype wire

[hw/rtl/sorted_symmetric_difference_core.sv]
`default_nettype none
// channel  | dir | fields                                  | accepted when
// i_req    | in  | op, index_value                         | valid && ready
// o_res    | out | element, valid_res, last, overflow      | valid && ready
//
// A load below capacity enters a sorted chain of 2*LIST_DEPTH cells; the
// request travels one cell per cycle and merges with an equal value or is
// inserted in order. A run holds the input while requests settle and then
// while the chain shifts toward cell 0, emitting each copy and dropping
// each cancelled entry; a closing step writes the final result.
// Synchronous active-low reset empties the chain. The output stalls the walk
// only while a finished result waits in the output register.
module sorted_symmetric_difference_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ssd_in_if.sink     i_req,
    ssd_out_if.source  o_res
);
    import ssd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam int DRN_W = $clog2(N_CELLS + 1);

    logic [1:0]            r_state, n_state;
    logic [DRN_W-1:0]      r_drn, n_drn;
    logic [CNT_W-1:0]      r_lcnt, n_lcnt, r_rcnt, n_rcnt;
    logic                  r_drop, n_drop;
    logic                  r_hvld, n_hvld;
    logic [INDEX_BITS-1:0] r_hval, n_hval;
    logic                  r_ovld, n_ovld;
    logic [ELEM_W-1:0]     r_oelem, n_oelem;
    logic                  r_ores, n_ores, r_olast, n_olast, r_oovf, n_oovf;

    t_entry    w_new;
    t_entry    w_ent   [N_CELLS];
    t_entry    w_tok   [N_CELLS];
    t_entry    w_right [N_CELLS];
    t_cell_ctl w_ctl;
    t_cell_ctl w_ctl0;

    logic w_acc, w_head_emit, w_out_free;
    logic [INDEX_BITS-1:0] w_val;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_val       = INDEX_BITS'(i_req.index_value);
    assign w_out_free  = !r_ovld || o_res.ready;
    // an entry present on both sides cancels out
    assign w_head_emit = w_ent[0].vld && !((w_ent[0].lcnt != '0) && w_ent[0].rflg);

    genvar g;
    generate
        for (g = 0; g < N_CELLS; g++) begin : g_cell
            if (g == N_CELLS - 1) begin : g_end
                assign w_right[g] = '0;
            end else begin : g_mid
                assign w_right[g] = w_ent[g+1];
            end
            if (g == 0) begin : g_head
                ssd_cell u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_ctl  (w_ctl0),
                    .i_tok  (w_new),
                    .i_right(w_right[g]),
                    .o_tok  (w_tok[g]),
                    .o_entry(w_ent[g])
                );
            end else begin : g_body
                ssd_cell u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_ctl  (w_ctl),
                    .i_tok  (w_tok[g-1]),
                    .i_right(w_right[g]),
                    .o_tok  (w_tok[g]),
                    .o_entry(w_ent[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_drn   = r_drn;
        n_lcnt  = r_lcnt;
        n_rcnt  = r_rcnt;
        n_drop  = r_drop;
        n_hvld  = r_hvld;
        n_hval  = r_hval;
        n_ovld  = r_ovld && !o_res.ready;
        n_oelem = r_oelem;
        n_ores  = r_ores;
        n_olast = r_olast;
        n_oovf  = r_oovf;
        w_new   = '0;
        w_ctl   = '0;
        w_ctl0  = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_req.op)
                        OP_LEFT: begin
                            if (r_lcnt < CNT_W'(LIST_DEPTH)) begin
                                w_new  = '{vld: 1'b1, value: w_val, lcnt: CNT_W'(1),
                                           rflg: 1'b0};
                                n_lcnt = r_lcnt + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        OP_RIGHT: begin
                            if (r_rcnt < CNT_W'(LIST_DEPTH)) begin
                                w_new  = '{vld: 1'b1, value: w_val, lcnt: '0, rflg: 1'b1};
                                n_rcnt = r_rcnt + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        OP_RUN: begin
                            n_state = ST_DRAIN;
                            n_drn   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                // let requests in flight settle into the chain
                n_drn = r_drn + DRN_W'(1);
                if (r_drn == DRN_W'(N_CELLS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_ent[0].vld) begin
                    if (!w_head_emit) begin
                        w_ctl.shift  = 1'b1;
                        w_ctl0.shift = 1'b1;
                    end else if (!r_hvld || w_out_free) begin
                        // release the held element, it is not the final one
                        if (r_hvld) begin
                            n_ovld  = 1'b1;
                            n_oelem = ELEM_W'(r_hval);
                            n_ores  = 1'b1;
                            n_olast = 1'b0;
                            n_oovf  = r_drop;
                        end
                        n_hvld = 1'b1;
                        n_hval = w_ent[0].value;
                        if (w_ent[0].lcnt > CNT_W'(1)) begin
                            w_ctl0.dec = 1'b1;
                        end else begin
                            w_ctl.shift  = 1'b1;
                            w_ctl0.shift = 1'b1;
                        end
                    end
                end else if (w_out_free) begin
                    // chain empty: close the run
                    n_ovld  = 1'b1;
                    n_oelem = r_hvld ? ELEM_W'(r_hval) : '0;
                    n_ores  = r_hvld;
                    n_olast = 1'b1;
                    n_oovf  = r_drop;
                    n_hvld  = 1'b0;
                    n_lcnt  = '0;
                    n_rcnt  = '0;
                    n_drop  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_drn   <= '0;
            r_lcnt  <= '0;
            r_rcnt  <= '0;
            r_drop  <= 1'b0;
            r_hvld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drn   <= n_drn;
            r_lcnt  <= n_lcnt;
            r_rcnt  <= n_rcnt;
            r_drop  <= n_drop;
            r_hvld  <= n_hvld;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hval  <= n_hval;
        r_oelem <= n_oelem;
        r_ores  <= n_ores;
        r_olast <= n_olast;
        r_oovf  <= n_oovf;
    end

    assign o_res.valid     = r_ovld;
    assign o_res.element   = r_oelem;
    assign o_res.valid_res = r_ores;
    assign o_res.last      = r_olast;
    assign o_res.overflow  = r_oovf;

    a_lcnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcnt <= CNT_W'(LIST_DEPTH) && r_rcnt <= CNT_W'(LIST_DEPTH))
        else $error("list count beyond capacity");

    a_no_tok_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> !w_tok[0].vld && !w_tok[N_CELLS-1].vld)
        else $error("request still in flight while emitting");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && n_state == ST_IDLE)
        |=> (r_lcnt == '0 && r_rcnt == '0 && !r_drop && !r_hvld && r_olast))
        else $error("run end did not clear state");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && n_state == ST_IDLE) |-> !w_ent[1].vld)
        else $error("chain not compact at run end");
endmodule
`default_nettype wire
